/* sv/pcxd_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants of the PCX run-length palette decoder.
// No dependencies.
package pcxd_pkg;

  localparam int PALETTE_ENTRIES = 256;

  localparam logic       OP_STREAM  = 1'b0;
  localparam logic       OP_PALETTE = 1'b1;
  localparam logic [7:0] RUN_MARK   = 8'hC0;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 17;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BYTES_PER_LINE = 2'd2;

  typedef enum logic {
    S_IDLE,
    S_RUN
  } state_t;

  typedef struct packed {
    logic                  we;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
  } cfg_wr_t;

  typedef struct packed {
    logic       start;
    logic [5:0] count;
    logic       step;
  } walk_ctl_t;

  typedef struct packed {
    logic blocked;
    logic visible;
    logic end_of_line;
    logic end_of_image;
    logic last_step;
    logic last_visible;
  } walk_sts_t;

endpackage

/* sv/pcxd_ifs.sv */
`timescale 1ns / 1ps
// Valid/ready channel interfaces: encoded input items and decoded pixels.
// No dependencies.
interface pcxd_in_if;
  logic        valid;
  logic        ready;
  logic        operation;
  logic [7:0]  data_byte;
  logic [7:0]  palette_index;
  logic [23:0] palette_rgb;

  modport source(output valid, operation, data_byte, palette_index, palette_rgb,
                 input ready);
  modport sink(input valid, operation, data_byte, palette_index, palette_rgb,
               output ready);
endinterface

interface pcxd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic       end_of_line;
  logic       end_of_image;
  logic       last_of_run;

  modport source(output valid, red, green, blue, end_of_line, end_of_image, last_of_run,
                 input ready);
  modport sink(input valid, red, green, blue, end_of_line, end_of_image, last_of_run,
               output ready);
endinterface

/* sv/pcxd_palette.sv */
`timescale 1ns / 1ps
// Palette RAM: one write port, one registered read port, no reset.
// No dependencies.
module pcxd_palette #(
  parameter int ENTRIES = 256
) (
  input  logic                       clk,
  input  logic                       we,
  input  logic [$clog2(ENTRIES)-1:0] waddr,
  input  logic [23:0]                wdata,
  input  logic                       re,
  input  logic [$clog2(ENTRIES)-1:0] raddr,
  output logic [23:0]                rdata
);

  logic [23:0] mem [ENTRIES];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* sv/pcxd_walker.sv */
`timescale 1ns / 1ps
// Geometry registers and the shared pixel step unit: column, row, bytes left, run count.
// Depends on pcxd_pkg.
module pcxd_walker (
  input  logic                clk,
  input  logic                rst,
  input  pcxd_pkg::cfg_wr_t   cfg,
  input  pcxd_pkg::walk_ctl_t ctl,
  output pcxd_pkg::walk_sts_t sts
);

  logic [16:0] image_width;
  logic [16:0] image_height;
  logic [15:0] bytes_per_line;
  logic [15:0] bytes_left;
  logic [16:0] column;
  logic [16:0] row;
  logic [5:0]  count;

  logic [16:0] vis;
  logic        eol;
  logic        line_end;

  always_comb begin
    vis      = (image_width < {1'b0, bytes_per_line}) ? image_width : {1'b0, bytes_per_line};
    eol      = (vis != 17'd0) && (column == vis - 17'd1);
    line_end = (bytes_left == 16'd1);
    sts.blocked      = (row >= image_height) || (bytes_per_line == 16'd0) ||
                       (bytes_left == 16'd0);
    sts.visible      = (column < image_width);
    sts.end_of_line  = eol;
    sts.end_of_image = eol && (({1'b0, row} + 18'd1) == {1'b0, image_height});
    sts.last_step    = (count == 6'd1) || line_end;
    sts.last_visible = (({1'b0, column} + 18'd1) == {1'b0, image_width});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width    <= 17'd1;
      image_height   <= 17'd1;
      bytes_per_line <= 16'd1;
      bytes_left     <= 16'd1;
      column         <= '0;
      row            <= '0;
      count          <= '0;
    end else begin
      if (cfg.we) begin
        unique case (cfg.index)
          pcxd_pkg::REG_IMAGE_WIDTH: begin
            image_width <= cfg.data;
          end
          pcxd_pkg::REG_IMAGE_HEIGHT: begin
            image_height <= cfg.data;
          end
          pcxd_pkg::REG_BYTES_PER_LINE: begin
            bytes_per_line <= cfg.data[15:0];
            bytes_left     <= cfg.data[15:0];
            column         <= '0;
          end
          default: begin
          end
        endcase
      end
      if (ctl.start) begin
        count <= ctl.count;
      end else if (ctl.step) begin
        count <= count - 6'd1;
        if (line_end) begin
          column     <= '0;
          row        <= row + 17'd1;
          bytes_left <= bytes_per_line;
        end else begin
          column     <= column + 17'd1;
          bytes_left <= bytes_left - 16'd1;
        end
      end
    end
  end

  a_line_sum: assert property (@(posedge clk) disable iff (rst)
    ({1'b0, column} + {2'b0, bytes_left}) == {2'b0, bytes_per_line})
    else $error("column and bytes_left out of step");

  a_step_count: assert property (@(posedge clk) disable iff (rst)
    ctl.step |-> (count != 6'd0))
    else $error("pixel step with empty run");

endmodule

/* sv/pcx_rle_palette_decoder.sv */
`timescale 1ns / 1ps
// PCX 8-bit run-length decoder with 256-entry RGB palette lookup.
// A pixel byte's palette read is registered; no new item is taken until its last pass.
// Palette writes, run headers and ignored bytes are taken in idle; a pixel byte takes
// min(count, bytes left in line) passes, one per pixel, held by output back-pressure.
// Reset returns geometry to 1 and clears position and control state; palette is kept.
module pcx_rle_palette_decoder #(
  parameter int PALETTE_ENTRIES = pcxd_pkg::PALETTE_ENTRIES
) (
  input  logic                                clk,
  input  logic                                rst,
  pcxd_in_if.sink                             stream,
  pcxd_out_if.source                          pixels,
  input  logic                                wr_en,
  input  logic [pcxd_pkg::CFG_IDX_W-1:0]      wr_index,
  input  logic [pcxd_pkg::CFG_DATA_W-1:0]     wr_data
);

  localparam int IdxW = $clog2(PALETTE_ENTRIES);

  pcxd_pkg::state_t    state;
  pcxd_pkg::state_t    state_next;
  pcxd_pkg::cfg_wr_t   cfg;
  pcxd_pkg::walk_ctl_t ctl;
  pcxd_pkg::walk_sts_t sts;

  logic        awaiting;
  logic [5:0]  run_length;
  logic        accept;
  logic        pal_we;
  logic        is_byte;
  logic [23:0] rgb;

  logic        out_valid;
  logic [7:0]  red;
  logic [7:0]  green;
  logic [7:0]  blue;
  logic        end_of_line;
  logic        end_of_image;
  logic        last_of_run;

  assign cfg.we    = wr_en;
  assign cfg.index = wr_index;
  assign cfg.data  = wr_data;

  always_comb begin
    stream.ready = (state == pcxd_pkg::S_IDLE);
    accept       = stream.valid && stream.ready;
    pal_we       = accept && (stream.operation == pcxd_pkg::OP_PALETTE);
    is_byte      = accept && (stream.operation == pcxd_pkg::OP_STREAM) && !sts.blocked;
    ctl.start    = is_byte && (awaiting ? (run_length != 6'd0)
                                        : (stream.data_byte < pcxd_pkg::RUN_MARK));
    ctl.count    = awaiting ? run_length : 6'd1;
    ctl.step     = (state == pcxd_pkg::S_RUN) && (!out_valid || pixels.ready);
  end

  always_comb begin
    state_next = state;
    unique case (state)
      pcxd_pkg::S_IDLE: begin
        if (ctl.start) begin
          state_next = pcxd_pkg::S_RUN;
        end
      end
      pcxd_pkg::S_RUN: begin
        if (ctl.step && sts.last_step) begin
          state_next = pcxd_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = pcxd_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= pcxd_pkg::S_IDLE;
      awaiting   <= 1'b0;
      run_length <= '0;
    end else begin
      state <= state_next;
      if (is_byte) begin
        if (awaiting) begin
          awaiting   <= 1'b0;
          run_length <= '0;
        end else if (stream.data_byte >= pcxd_pkg::RUN_MARK) begin
          awaiting   <= 1'b1;
          run_length <= stream.data_byte[5:0];
        end
      end
    end
  end

  pcxd_palette #(
    .ENTRIES(PALETTE_ENTRIES)
  ) u_palette (
    .clk  (clk),
    .we   (pal_we),
    .waddr(stream.palette_index[IdxW-1:0]),
    .wdata(stream.palette_rgb),
    .re   (ctl.start),
    .raddr(stream.data_byte[IdxW-1:0]),
    .rdata(rgb)
  );

  pcxd_walker u_walker (
    .clk(clk),
    .rst(rst),
    .cfg(cfg),
    .ctl(ctl),
    .sts(sts)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.step && sts.visible) begin
      out_valid <= 1'b1;
    end else if (pixels.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.step && sts.visible) begin
      red          <= rgb[23:16];
      green        <= rgb[15:8];
      blue         <= rgb[7:0];
      end_of_line  <= sts.end_of_line;
      end_of_image <= sts.end_of_image;
      last_of_run  <= sts.last_step || sts.last_visible;
    end
  end

  assign pixels.valid        = out_valid;
  assign pixels.red          = red;
  assign pixels.green        = green;
  assign pixels.blue         = blue;
  assign pixels.end_of_line  = end_of_line;
  assign pixels.end_of_image = end_of_image;
  assign pixels.last_of_run  = last_of_run;

  a_eol_ends_run: assert property (@(posedge clk) disable iff (rst)
    (pixels.valid && pixels.end_of_line) |-> pixels.last_of_run)
    else $error("line end pixel not last of its run");

  a_eoi_is_eol: assert property (@(posedge clk) disable iff (rst)
    (pixels.valid && pixels.end_of_image) |-> pixels.end_of_line)
    else $error("image end without line end");

  a_run_continues: assert property (@(posedge clk) disable iff (rst)
    (pixels.valid && pixels.ready && !pixels.last_of_run) |=> pixels.valid)
    else $error("run broke off before its last pixel");

endmodule
